// ===== rtl/lseg_pkg.sv =====
`default_nettype none
package lseg_pkg;

    localparam int IDX_W   = 6;
    localparam int LVL_W   = 8;
    localparam int PHASE_W = 9;
    localparam int HUE_W   = 9;
    localparam int MODE_W  = 3;
    localparam int COL_W   = 4;
    localparam int RGB_W   = 3 * LVL_W;

    localparam logic [MODE_W-1:0] MODE_STATIC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FLASH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHASE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BREATHE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd4;

    localparam logic [COL_W-1:0] COL_WHITE  = 4'd0;
    localparam logic [COL_W-1:0] COL_RED    = 4'd1;
    localparam logic [COL_W-1:0] COL_ORANGE = 4'd2;
    localparam logic [COL_W-1:0] COL_YELLOW = 4'd3;
    localparam logic [COL_W-1:0] COL_GREEN  = 4'd4;
    localparam logic [COL_W-1:0] COL_BLUE   = 4'd5;
    localparam logic [COL_W-1:0] COL_INDIGO = 4'd6;
    localparam logic [COL_W-1:0] COL_PURPLE = 4'd7;
    localparam logic [COL_W-1:0] COL_OFF    = 4'd8;

    localparam logic [1:0] REG_POWER  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_COLOUR = 2'd2;
    localparam logic [1:0] REG_BRIGHT = 2'd3;

    localparam logic [1:0] CH_NONE = 2'd0;
    localparam logic [1:0] CH_HALF = 2'd1;
    localparam logic [1:0] CH_FULL = 2'd2;

    localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;
    localparam logic [HUE_W-1:0] HUE_SEG    = 9'd120;
    localparam logic [HUE_W-1:0] HUE_SEG2   = 9'd240;
    localparam logic [LVL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [LVL_W-1:0] BRIGHT_RST = 8'd100;

    localparam logic [PHASE_W:0] FLASH_PERIOD   = 10'd2;
    localparam logic [PHASE_W:0] BREATHE_PERIOD = 10'd512;
    localparam logic [PHASE_W:0] STATIC_PERIOD  = 10'd1;

    typedef struct packed {
        logic                power;
        logic [MODE_W-1:0]   mode;
        logic [COL_W-1:0]    colour;
        logic [LVL_W-1:0]    level;
        logic [PHASE_W-1:0]  phase;
        logic [IDX_W-1:0]    index;
    } shade_ctrl_t;

    function automatic logic [MODE_W-1:0] mode_clamp(input logic [MODE_W-1:0] m);
        return (m > MODE_RAINBOW) ? MODE_STATIC : m;
    endfunction

    function automatic logic [COL_W-1:0] colour_clamp(input logic [COL_W-1:0] c);
        return (c > COL_OFF) ? COL_OFF : c;
    endfunction

    function automatic logic [LVL_W-1:0] chan(input logic [1:0] sel, input logic [LVL_W-1:0] lvl);
        logic [LVL_W-1:0] v;
        case (sel)
            CH_FULL: v = lvl;
            CH_HALF: v = lvl >> 1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // {red, green, blue}, red in the top byte
    function automatic logic [RGB_W-1:0] paint(input logic [COL_W-1:0] c,
                                               input logic [LVL_W-1:0] lvl);
        logic [5:0] sel;
        case (c)
            COL_WHITE:  sel = {CH_FULL, CH_FULL, CH_FULL};
            COL_RED:    sel = {CH_FULL, CH_NONE, CH_NONE};
            COL_ORANGE: sel = {CH_FULL, CH_HALF, CH_NONE};
            COL_YELLOW: sel = {CH_FULL, CH_FULL, CH_NONE};
            COL_GREEN:  sel = {CH_NONE, CH_FULL, CH_NONE};
            COL_BLUE:   sel = {CH_NONE, CH_NONE, CH_FULL};
            COL_INDIGO: sel = {CH_NONE, CH_HALF, CH_FULL};
            COL_PURPLE: sel = {CH_HALF, CH_NONE, CH_FULL};
            default:    sel = {CH_NONE, CH_NONE, CH_NONE};
        endcase
        return {chan(sel[5:4], lvl), chan(sel[3:2], lvl), chan(sel[1:0], lvl)};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lseg_scale.sv =====
`default_nettype none
module lseg_scale (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [lseg_pkg::LVL_W-1:0] op_a,
    input  wire logic [lseg_pkg::LVL_W-1:0] op_b,
    output logic      [lseg_pkg::LVL_W-1:0] q
);
    import lseg_pkg::*;

    logic [2*LVL_W-1:0] prod_reg;
    logic [2*LVL_W:0]   adj;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    // floor(p / 255), exact for products of two 8-bit values
    assign adj = {1'b0, prod_reg} + {{(LVL_W+1){1'b0}}, prod_reg[2*LVL_W-1:LVL_W]}
               + {{(2*LVL_W){1'b0}}, 1'b1};
    assign q   = adj[2*LVL_W-1:LVL_W];

endmodule
`default_nettype wire

// ===== rtl/lseg_shade.sv =====
`default_nettype none
module lseg_shade #(
    parameter int LED_COUNT = 8
) (
    input  wire logic                       [lseg_pkg::HUE_W-1:0] hue,
    input  wire lseg_pkg::shade_ctrl_t      ctrl,
    input  wire logic                       [lseg_pkg::LVL_W-1:0] res_a,
    input  wire logic                       [lseg_pkg::LVL_W-1:0] res_b,
    output logic                            [lseg_pkg::LVL_W-1:0] op_a,
    output logic                            [lseg_pkg::LVL_W-1:0] op_b,
    output logic                            [lseg_pkg::RGB_W-1:0] rgb
);
    import lseg_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

    logic [MODE_W-1:0] mode;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  col_white_off;
    logic [6:0]        x;
    logic [6:0]        y;
    logic [10:0]       up17;
    logic [10:0]       down17;
    logic [1:0]        seg;
    logic [IDX_W-1:0]  p_lo;
    logic [IDX_W-1:0]  p_nxt;
    logic              hit;

    always_comb begin
        mode          = mode_clamp(ctrl.mode);
        col           = colour_clamp(ctrl.colour);
        col_white_off = (col == COL_OFF) ? COL_WHITE : col;

        if (hue >= HUE_SEG2) begin
            seg = 2'd2;
            x   = 7'(hue - HUE_SEG2);
        end else if (hue >= HUE_SEG) begin
            seg = 2'd1;
            x   = 7'(hue - HUE_SEG);
        end else begin
            seg = 2'd0;
            x   = hue[6:0];
        end
        y      = 7'(HUE_SEG) - x;
        up17   = {x, 4'b0} + {4'b0, x};
        down17 = {y, 4'b0} + {4'b0, y};
        op_a   = down17[10:3];
        op_b   = up17[10:3];

        p_lo  = ctrl.phase[IDX_W-1:0];
        p_nxt = (p_lo == LAST_IDX) ? '0 : p_lo + 1'b1;
        hit   = (ctrl.index == p_lo) || (ctrl.index == p_nxt);

        rgb = '0;
        if (ctrl.power) begin
            case (mode)
                MODE_FLASH: begin
                    rgb = paint((col == COL_INDIGO || col == COL_OFF) ? COL_WHITE : col,
                                ctrl.phase[0] ? LEVEL_MAX : '0);
                end
                MODE_CHASE: begin
                    if (hit) begin
                        rgb = paint(col_white_off, ctrl.level);
                    end
                end
                MODE_BREATHE: begin
                    if (!ctrl.phase[PHASE_W-1]) begin
                        rgb = paint(col, ctrl.phase[LVL_W-1:0]);
                    end else begin
                        rgb = paint(col_white_off, ~ctrl.phase[LVL_W-1:0]);
                    end
                end
                MODE_RAINBOW: begin
                    case (seg)
                        2'd0:    rgb = {res_a, res_b, {LVL_W{1'b0}}};
                        2'd1:    rgb = {{LVL_W{1'b0}}, res_a, res_b};
                        default: rgb = {res_b, {LVL_W{1'b0}}, res_a};
                    endcase
                end
                default: begin
                    rgb = paint(col, ctrl.level);
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/led_strip_effect_generator_core.sv =====
`default_nettype none
// LED strip effect generator. Each accepted s_ transaction (bit 0 = advance)
// produces one frame of LED_COUNT m_ transactions, one per pixel in index
// order, m_tlast on the final pixel. Every pixel passes through one shared
// 8x8 multiplier with a divide-by-255 correction, two products per pixel
// (used by rainbow effect); s_tready is low while a frame is in progress.
// Configuration writes are taken any time but must be issued only while
// the block is idle; writing effect_mode restarts the effect phase.
module led_strip_effect_generator_core #(
    parameter int LED_COUNT = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] advance, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [5:0] led_index, [13:6] red, [21:14] green,
                                        // [29:22] blue, [31:30] zero
    output logic             m_tlast,   // frame_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import lseg_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
    localparam logic [HUE_W-1:0] HUE_STEP = HUE_W'(360 / LED_COUNT);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL_A = 4'b0010,
        ST_MUL_B = 4'b0100,
        ST_PUT   = 4'b1000
    } state_t;

    state_t             state_reg,  state_next;
    logic               power_reg,  power_next;
    logic [MODE_W-1:0]  mode_reg,   mode_next;
    logic [COL_W-1:0]   colour_reg, colour_next;
    logic [LVL_W-1:0]   bright_reg, bright_next;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [HUE_W-1:0]   hue_reg,    hue_next;
    logic               adv_reg,    adv_next;
    logic [LVL_W-1:0]   res_a_reg,  res_a_next;
    logic               mval_reg,   mval_next;
    logic [29:0]        mdata_reg,  mdata_next;
    logic               mlast_reg,  mlast_next;

    logic [PHASE_W:0]   period;
    logic [PHASE_W:0]   phase_inc;
    logic [PHASE_W-1:0] phase_adv;
    logic [HUE_W:0]     hue_sum;
    logic [HUE_W-1:0]   hue_step_next;
    logic               out_free;
    logic               mul_en;
    logic [LVL_W-1:0]   mul_a;
    logic [LVL_W-1:0]   op_a;
    logic [LVL_W-1:0]   op_b;
    logic [LVL_W-1:0]   mul_q;
    logic [RGB_W-1:0]   rgb;
    shade_ctrl_t        ctrl;

    assign ctrl = '{power:  power_reg,
                    mode:   mode_reg,
                    colour: colour_reg,
                    level:  bright_reg,
                    phase:  phase_reg,
                    index:  idx_reg};

    lseg_shade #(
        .LED_COUNT(LED_COUNT)
    ) u_shade (
        .hue   (hue_reg),
        .ctrl  (ctrl),
        .res_a (res_a_reg),
        .res_b (mul_q),
        .op_a  (op_a),
        .op_b  (op_b),
        .rgb   (rgb)
    );

    assign mul_en = (state_reg == ST_MUL_A) || (state_reg == ST_MUL_B);
    assign mul_a  = (state_reg == ST_MUL_B) ? op_b : op_a;

    lseg_scale u_scale (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (bright_reg),
        .q    (mul_q)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mval_reg;
    assign m_tdata   = {2'b00, mdata_reg};
    assign m_tlast   = mlast_reg;
    assign out_free  = !mval_reg || m_tready;

    always_comb begin
        case (mode_clamp(mode_reg))
            MODE_FLASH:   period = FLASH_PERIOD;
            MODE_CHASE:   period = (PHASE_W+1)'(LED_COUNT);
            MODE_BREATHE: period = BREATHE_PERIOD;
            MODE_RAINBOW: period = {1'b0, HUE_FULL};
            default:      period = STATIC_PERIOD;
        endcase
        phase_inc = {1'b0, phase_reg} + 1'b1;
        phase_adv = (phase_inc == period) ? '0 : phase_inc[PHASE_W-1:0];

        hue_sum       = {1'b0, hue_reg} + {1'b0, HUE_STEP};
        hue_step_next = (hue_sum >= {1'b0, HUE_FULL}) ? HUE_W'(hue_sum - {1'b0, HUE_FULL})
                                                      : hue_sum[HUE_W-1:0];
    end

    always_comb begin
        state_next  = state_reg;
        power_next  = power_reg;
        mode_next   = mode_reg;
        colour_next = colour_reg;
        bright_next = bright_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        hue_next    = hue_reg;
        adv_next    = adv_reg;
        res_a_next  = res_a_reg;
        mval_next   = mval_reg && !m_tready;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    adv_next   = s_tdata[0];
                    hue_next   = phase_reg;
                    idx_next   = '0;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                res_a_next = mul_q;
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (out_free) begin
                    mval_next  = 1'b1;
                    mdata_next = {rgb[7:0], rgb[15:8], rgb[23:16], idx_reg};
                    mlast_next = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX) begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                        if (power_reg && adv_reg) begin
                            phase_next = phase_adv;
                        end
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        hue_next   = hue_step_next;
                        state_next = ST_MUL_A;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            case (cfg_index)
                REG_POWER:  power_next  = cfg_data[0];
                REG_MODE: begin
                    mode_next  = cfg_data[MODE_W-1:0];
                    phase_next = '0;
                end
                REG_COLOUR: colour_next = cfg_data[COL_W-1:0];
                REG_BRIGHT: bright_next = cfg_data;
                default:    power_next  = power_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            power_reg  <= 1'b0;
            mode_reg   <= MODE_STATIC;
            colour_reg <= COL_WHITE;
            bright_reg <= BRIGHT_RST;
            phase_reg  <= '0;
            idx_reg    <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            power_reg  <= power_next;
            mode_reg   <= mode_next;
            colour_reg <= colour_next;
            bright_reg <= bright_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            mval_reg   <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        hue_reg   <= hue_next;
        adv_reg   <= adv_next;
        res_a_reg <= res_a_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    a_phase_in_period: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, phase_reg} < period)
        else $error("effect phase outside its period");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[IDX_W-1:0] == LAST_IDX))
        else $error("frame end on wrong pixel");

    a_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (idx_reg == '0))
        else $error("pixel counter not cleared at frame end");

    a_put_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_B) |-> $past(state_reg == ST_MUL_A))
        else $error("second product issued without first");

endmodule
`default_nettype wire
